>>> sv/glu_pkg.sv
// Package for the gcd/lcm unit: widths, operation codes, word types.
// No dependencies.
`default_nettype none
package glu_pkg;
	localparam int OperandWidth = 32;
	localparam int MagWidth = OperandWidth - 1;
	localparam int AnswerWidth = 62;
	localparam int QueueDepth = 2;

	localparam logic EBOB = 1'b0;  // greatest common divisor
	localparam logic EKOK = 1'b1;  // least common multiple

	typedef struct packed {
		logic func;
		logic signed [31:0] first_number;
		logic signed [31:0] second_number;
	} in_word_t;

	typedef struct packed {
		logic [AnswerWidth-1:0] answer;
		logic bad_operand;
	} out_word_t;

	// classified job between front and back
	typedef struct packed {
		logic func;
		logic bad;
		logic zero;
		logic [MagWidth-1:0] a;
		logic [MagWidth-1:0] b;
	} job_t;
endpackage
`default_nettype wire

>>> sv/glu_front.sv
// Front end: accepts input words, checks signs, queues classified jobs.
// Depends on glu_pkg.
`default_nettype none
module glu_front import glu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire in_word_t in_word,
	output logic job_valid,
	input  wire logic job_take,
	output job_t job
);
	job_t mem_q [QueueDepth];
	logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
	logic [$clog2(QueueDepth):0] cnt_q;
	logic [OperandWidth-1:0] ra, rb;
	job_t nj;
	logic do_push, do_pop;

	assign ra = in_word.first_number[OperandWidth-1:0];
	assign rb = in_word.second_number[OperandWidth-1:0];
	always_comb begin
		nj.func = in_word.func;
		nj.bad = ra[OperandWidth-1] | rb[OperandWidth-1];
		nj.a = ra[MagWidth-1:0];
		nj.b = rb[MagWidth-1:0];
		nj.zero = (nj.a == '0) || (nj.b == '0);
	end

	assign full = (cnt_q == QueueDepth[$clog2(QueueDepth):0]);
	assign job_valid = (cnt_q != '0);
	assign job = mem_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop = job_take & job_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> sv/glu_back.sv
// Back end: binary gcd, then a shift-add multiply and a restoring divide
// for lcm = (a*b)/g. Holds one finished result word. Depends on glu_pkg.
`default_nettype none
module glu_back import glu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic job_take,
	input  wire job_t job,
	output logic empty,
	input  wire logic pop,
	output out_word_t out_word
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam int PW = 2 * MagWidth;
	localparam int CW = $clog2(PW + 1);

	logic [2:0] state_q;
	logic func_q;
	logic [MagWidth-1:0] a_q, b_q, u_q, v_q, g_q;
	logic [$clog2(MagWidth+1)-1:0] k_q;
	logic [PW-1:0] p_q, rem_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic full_q;
	out_word_t res_q;
	logic [PW:0] trial;
	logic [MagWidth-1:0] diff;

	assign empty = ~full_q;
	assign out_word = res_q;
	assign job_take = job_valid && (state_q == ST_IDLE) && !full_q;
	assign trial = {rem_q, p_q[PW-1]} - {1'b0, {MagWidth{1'b0}}, g_q};
	assign diff = (u_q > v_q) ? (u_q - v_q) : (v_q - u_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= job.func;
				a_q <= job.a;
				b_q <= job.b;
				u_q <= job.a;
				v_q <= job.b;
				k_q <= '0;
			end
			ST_GCD: begin
				// strip common twos, then subtract odd from odd
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) u_q <= u_q >> 1;
				else if (!v_q[0]) v_q <= v_q >> 1;
				else begin
					u_q <= (u_q < v_q) ? u_q : v_q;
					v_q <= diff;
				end
				g_q <= u_q << k_q;
				p_q <= '0;
				cnt_q <= '0;
			end
			ST_MUL: begin
				if (b_q[0]) p_q <= p_q + (PW'(a_q) << cnt_q);
				b_q <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (!trial[PW]) begin
					rem_q <= trial[PW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[PW-2:0], p_q[PW-1]};
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
				p_q <= p_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (pop && full_q) full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (job_take) begin
					if (job.bad || (job.func == EKOK && job.zero)) begin
						res_q.answer <= '0;
						res_q.bad_operand <= job.bad;
						full_q <= 1'b1;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (u_q == '0 || v_q == '0) begin
						// one side zero: other side is the odd part
						if (func_q == EBOB) begin
							res_q.answer <= AnswerWidth'((u_q | v_q) << k_q);
							res_q.bad_operand <= 1'b0;
							state_q <= ST_DONE;
						end else state_q <= ST_MUL;
					end
				end
				ST_MUL: if (cnt_q == CW'(MagWidth - 1)) state_q <= ST_DIV;
				ST_DIV: if (cnt_q == CW'(MagWidth + PW - 1)) begin
					state_q <= ST_DONE;
				end
				ST_DONE: if (!full_q) begin
					if (func_q == EKOK) begin
						res_q.answer <= AnswerWidth'(quo_q);
						res_q.bad_operand <= 1'b0;
					end
					full_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/gcd_lcm_unit_top.sv
// Gcd/lcm unit: for each word the unit answers gcd or lcm of two
// non-negative operands; a negative operand gives bad_operand and zero.
// An item runs binary gcd and, for lcm, a shift-add multiply and a
// restoring divide on the one shared iterative datapath in the back end;
// a rejected word or a zero-operand lcm is answered straight from idle.
// A two-entry job queue and one result register let the sides stall
// independently.
`default_nettype none
module gcd_lcm_unit_top import glu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire in_word_t in_word,
	output logic empty,
	input  wire logic pop,
	output out_word_t out_word
);
	logic job_valid, job_take;
	job_t job;

	glu_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.job_valid, .job_take, .job
	);
	glu_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job,
		.empty, .pop, .out_word
	);
endmodule
`default_nettype wire

>>> tb/sv/gcd_lcm_unit_top_tb.sv
// Testbench for the gcd/lcm unit: directed table, then random words in idle and stall phases.
// Predicts each answer in place and checks results in order; depends on glu_pkg.
`default_nettype none
module gcd_lcm_unit_top_tb;
	import glu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic func;
		logic [31:0] a;
		logic [31:0] b;
		logic known;
		out_word_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_word_t in_word;
	logic empty;
	logic pop;
	out_word_t out_word;

	out_word_t answers_due[$];
	int errors;
	int idle_pct;
	int stall_pct;
	row_t dir_rows[$];

	gcd_lcm_unit_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("gcd_lcm_unit_top_tb failed");
		$finish;
	end

	function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic out_word_t predict_answer(logic func, logic [31:0] a, logic [31:0] b);
		out_word_t w;
		logic [63:0] g;
		w = '0;
		if (a[OperandWidth-1] || b[OperandWidth-1]) begin
			w.bad_operand = 1'b1;
		end else if (func == EBOB) begin
			w.answer = 62'(euclid({32'd0, a}, {32'd0, b}));
		end else if (a != 0 && b != 0) begin
			g = euclid({32'd0, a}, {32'd0, b});
			w.answer = 62'(({32'd0, a} / g) * {32'd0, b});
		end
		return w;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom_range(1, 20);
			2: return 32'h7fff_ffff - $urandom_range(0, 3);
			3: return 32'h8000_0000 | $urandom();
			4, 5: return $urandom_range(1, 5000) * $urandom_range(1, 300);
			default: return {1'b0, 31'($urandom())};
		endcase
	endfunction

	task automatic send_word(logic func, logic [31:0] a, logic [31:0] b, logic known,
			out_word_t res);
		in_word_t w;
		w.func = func;
		w.first_number = a;
		w.second_number = b;
		// drop push while idling
		while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		answers_due.push_back(known ? res : predict_answer(func, a, b));
	endtask

	// receiver: stall at random, check each accepted word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_word);
					errors++;
				end else begin
					if (out_word.answer !== answers_due[0].answer) begin
						$display("%0t: answer expected %0d got %0d", $time,
							answers_due[0].answer, out_word.answer);
						errors++;
					end
					if (out_word.bad_operand !== answers_due[0].bad_operand) begin
						$display("%0t: bad_operand expected %b got %b", $time,
							answers_due[0].bad_operand, out_word.bad_operand);
						errors++;
					end
					void'(answers_due.pop_front());
				end
			end
			pop <= !(stall_pct > 0 && $urandom_range(1, 100) <= stall_pct);
		end
	end

	function automatic row_t mk(logic f, logic [31:0] a, logic [31:0] b, logic k,
			logic [61:0] ans, logic bad);
		row_t r;
		r.func = f;
		r.a = a;
		r.b = b;
		r.known = k;
		r.res.answer = ans;
		r.res.bad_operand = bad;
		return r;
	endfunction

	initial begin
		logic f;
		logic [31:0] a;
		logic [31:0] b;
		out_word_t none;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		none = '0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_word = '0;
		dir_rows.push_back(mk(EBOB, 32'd0, 32'd0, 1'b1, 62'd0, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'd0, 32'd0, 1'b1, 62'd0, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'd7, 32'd0, 1'b1, 62'd7, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'd0, 32'd9, 1'b1, 62'd9, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'd5, 32'd0, 1'b1, 62'd0, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'd0, 32'd5, 1'b1, 62'd0, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'h8000_0000, 32'd4, 1'b1, 62'd0, 1'b1));
		dir_rows.push_back(mk(EKOK, 32'd4, 32'hffff_ffff, 1'b1, 62'd0, 1'b1));
		dir_rows.push_back(mk(EBOB, 32'hffff_ffff, 32'h8000_0000, 1'b1, 62'd0, 1'b1));
		dir_rows.push_back(mk(EKOK, 32'h8000_0000, 32'd0, 1'b1, 62'd0, 1'b1));
		dir_rows.push_back(mk(EBOB, 32'd1, 32'd1, 1'b1, 62'd1, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'd1, 32'd1, 1'b1, 62'd1, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 62'h7fff_ffff,
			1'b0));
		dir_rows.push_back(mk(EKOK, 32'h7fff_ffff, 32'h7fff_fffe, 1'b1,
			62'h3fff_fffe_8000_0002, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'd12, 32'd18, 1'b1, 62'd6, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'd12, 32'd18, 1'b1, 62'd36, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'h4000_0000, 32'h0000_0400, 1'b0, 62'd0, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'h5555_5555, 32'h2aaa_aaaa, 1'b0, 62'd0, 1'b0));
		dir_rows.push_back(mk(EKOK, 32'h7fff_fffd, 32'h7fff_ffff, 1'b0, 62'd0, 1'b0));
		dir_rows.push_back(mk(EBOB, 32'd1836311903, 32'd1134903170, 1'b0, 62'd0, 1'b0));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].func, dir_rows[i].a, dir_rows[i].b, dir_rows[i].known,
				dir_rows[i].res);
		for (int n = 0; n < 450; n++) begin
			case (n / 90)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 45; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 45; end
				3: begin idle_pct = 33; stall_pct = 33; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			// hold off until the unit drains once
			if (n == 200) begin
				push <= 1'b0;
				while (answers_due.size() != 0) @(posedge clk);
			end
			f = 1'($urandom_range(0, 1));
			a = rand_operand();
			b = rand_operand();
			send_word(f, a, b, 1'b0, none);
		end
		push <= 1'b0;
		stall_pct = 0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0) begin
			$display("gcd_lcm_unit_top_tb passed");
		end else begin
			$display("gcd_lcm_unit_top_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
